// File: hdl/dllm_pkg.sv
// Shared types and codes for the doubly linked list manager.
package dllm_pkg;

   localparam int OP_W = 3;

   // Operation codes carried by an input item; the two unused codes answer none.
   typedef enum logic [OP_W-1:0] {
      OP_INSERT_AFTER = 3'd0,
      OP_DETACH       = 3'd1,
      OP_FIND         = 3'd2,
      OP_PUSH_BACK    = 3'd3,
      OP_PUSH_FRONT   = 3'd4,
      OP_POP_FRONT    = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_INS_AFTER,
      ST_INS_CHECK,
      ST_INS_WR_SELF,
      ST_INS_WR_NBR,
      ST_DET_CHECK,
      ST_DET_WR_NBR,
      ST_DET_WR_SELF,
      ST_FIND_RD,
      ST_FIND_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_TARGET,
      RD_AFTER,
      RD_CURSOR
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_INS_SELF,
      WR_INS_NBR,
      WR_DET_SELF,
      WR_DET_NBR
   } wr_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      logic       cap_links;
      logic       cap_nxt;
      logic       upd_ins;
      logic       upd_det;
      logic       find_step;
      logic       set_found;
      logic       clr_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   target_ok;
      logic   after_none;
      logic   rd_member;
      logic   cursor_done;
      logic   cursor_hit;
      logic   clr_last;
      logic   rsp_free;
   } status_type;

endpackage

// File: hdl/dllm_channels.sv
// Valid/ready channel interfaces for list operations and their results.
interface dllm_req_if #(
   parameter int ITEM_W = 6,
   parameter int LINK_W = 7
);
   logic                       valid;
   logic                       ready;
   logic [dllm_pkg::OP_W-1:0]  operation;
   logic [ITEM_W-1:0]          item_index;
   logic [LINK_W-1:0]          prev_index;

   modport source (output valid, output operation, output item_index, output prev_index,
                   input ready);
   modport sink (input valid, input operation, input item_index, input prev_index,
                 output ready);
   modport monitor (input valid, input ready, input operation, input item_index,
                    input prev_index);
endinterface

interface dllm_rsp_if #(
   parameter int LINK_W = 7
);
   logic              valid;
   logic              ready;
   logic [LINK_W-1:0] result_index;
   logic [LINK_W-1:0] list_count;
   logic [LINK_W-1:0] head_index;
   logic [LINK_W-1:0] tail_index;

   modport source (output valid, output result_index, output list_count,
                   output head_index, output tail_index, input ready);
   modport sink (input valid, input result_index, input list_count,
                 input head_index, input tail_index, output ready);
   modport monitor (input valid, input ready, input result_index, input list_count,
                    input head_index, input tail_index);
endinterface

// File: hdl/dllm_ctrl.sv
// Sequencer that steps each list operation through the link memories.
module dllm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dllm_pkg::status_type  status,
   output dllm_pkg::cmd_type     cmd
);

   dllm_pkg::state_type state_ff;
   dllm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dllm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         dllm_pkg::ST_CLEAR: begin
            cmd.wr_sel   = dllm_pkg::WR_CLEAR;
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = dllm_pkg::ST_IDLE;
            end
         end
         dllm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = dllm_pkg::ST_DECODE;
            end
         end
         dllm_pkg::ST_DECODE: begin
            if (!status.target_ok) begin
               state_in = dllm_pkg::ST_FINISH;
            end else begin
               unique case (status.op) inside
                  dllm_pkg::OP_INSERT_AFTER, dllm_pkg::OP_PUSH_BACK,
                  dllm_pkg::OP_PUSH_FRONT: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = dllm_pkg::RD_TARGET;
                     state_in   = dllm_pkg::ST_INS_AFTER;
                  end
                  dllm_pkg::OP_DETACH, dllm_pkg::OP_POP_FRONT: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = dllm_pkg::RD_TARGET;
                     state_in   = dllm_pkg::ST_DET_CHECK;
                  end
                  dllm_pkg::OP_FIND: begin
                     state_in = dllm_pkg::ST_FIND_RD;
                  end
                  default: begin
                     state_in = dllm_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         dllm_pkg::ST_INS_AFTER: begin
            // refuse a node that is already on the list
            if (status.rd_member) begin
               state_in = dllm_pkg::ST_FINISH;
            end else if (status.after_none) begin
               cmd.cap_nxt = 1'b1;
               state_in    = dllm_pkg::ST_INS_WR_SELF;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = dllm_pkg::RD_AFTER;
               state_in   = dllm_pkg::ST_INS_CHECK;
            end
         end
         dllm_pkg::ST_INS_CHECK: begin
            if (!status.rd_member) begin
               state_in = dllm_pkg::ST_FINISH;
            end else begin
               cmd.cap_nxt = 1'b1;
               state_in    = dllm_pkg::ST_INS_WR_SELF;
            end
         end
         dllm_pkg::ST_INS_WR_SELF: begin
            cmd.wr_sel = dllm_pkg::WR_INS_SELF;
            state_in   = dllm_pkg::ST_INS_WR_NBR;
         end
         dllm_pkg::ST_INS_WR_NBR: begin
            cmd.wr_sel  = dllm_pkg::WR_INS_NBR;
            cmd.upd_ins = 1'b1;
            state_in    = dllm_pkg::ST_FINISH;
         end
         dllm_pkg::ST_DET_CHECK: begin
            if (!status.rd_member) begin
               state_in = dllm_pkg::ST_FINISH;
            end else begin
               cmd.cap_links = 1'b1;
               state_in      = dllm_pkg::ST_DET_WR_NBR;
            end
         end
         dllm_pkg::ST_DET_WR_NBR: begin
            cmd.wr_sel = dllm_pkg::WR_DET_NBR;
            state_in   = dllm_pkg::ST_DET_WR_SELF;
         end
         dllm_pkg::ST_DET_WR_SELF: begin
            cmd.wr_sel  = dllm_pkg::WR_DET_SELF;
            cmd.upd_det = 1'b1;
            state_in    = dllm_pkg::ST_FINISH;
         end
         dllm_pkg::ST_FIND_RD: begin
            if (status.cursor_done) begin
               state_in = dllm_pkg::ST_FINISH;
            end else if (status.cursor_hit) begin
               cmd.set_found = 1'b1;
               state_in      = dllm_pkg::ST_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = dllm_pkg::RD_CURSOR;
               state_in   = dllm_pkg::ST_FIND_WAIT;
            end
         end
         dllm_pkg::ST_FIND_WAIT: begin
            cmd.find_step = 1'b1;
            state_in      = dllm_pkg::ST_FIND_RD;
         end
         dllm_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = dllm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dllm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/dllm_datapath.sv
// Link memories, list registers and result register of the list manager.
module dllm_datapath #(
   parameter  int NODES = 64,
   localparam int IW    = $clog2(NODES),
   localparam int LW    = $clog2(NODES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dllm_pkg::cmd_type         cmd,
   output dllm_pkg::status_type      status,
   input  logic [dllm_pkg::OP_W-1:0] req_operation,
   input  logic [IW-1:0]             req_item_index,
   input  logic [LW-1:0]             req_prev_index,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [LW-1:0]             rsp_result_index,
   output logic [LW-1:0]             rsp_list_count,
   output logic [LW-1:0]             rsp_head_index,
   output logic [LW-1:0]             rsp_tail_index
);

   localparam logic [LW-1:0] NONE = LW'(NODES);
   localparam logic [IW-1:0] LAST = IW'(NODES - 1);

   logic [LW-1:0] next_mem [NODES];
   logic [LW-1:0] prev_mem [NODES];

   dllm_pkg::op_type op_ff, op_in;
   logic [LW-1:0] tgt_ff, tgt_in;
   logic [LW-1:0] after_ff, after_in;
   logic [LW-1:0] nxt_ff, nxt_in;
   logic [LW-1:0] p_ff, p_in;
   logic [LW-1:0] n_ff, n_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] steps_ff, steps_in;
   logic [LW-1:0] res_ff, res_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] tail_ff, tail_in;
   logic [LW-1:0] count_ff, count_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [LW-1:0] rd_next_ff, rd_prev_ff, rd_addr_ff, rd_addr;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] out_res_ff, out_count_ff, out_head_ff, out_tail_ff;

   logic          wn_en, wp_en;
   logic [IW-1:0] wn_addr, wp_addr;
   logic [LW-1:0] wn_data, wp_data;

   logic [LW-1:0] item_ext, prev_mapped, item_mapped;

   // Request capture and list register updates
   always_comb begin
      item_ext    = LW'(req_item_index);
      item_mapped = (item_ext < NONE) ? item_ext : NONE;
      prev_mapped = (req_prev_index < NONE) ? req_prev_index : NONE;

      op_in    = op_ff;
      tgt_in   = tgt_ff;
      after_in = after_ff;
      nxt_in   = nxt_ff;
      p_in     = p_ff;
      n_in     = n_ff;
      cur_in   = cur_ff;
      steps_in = steps_ff;
      res_in   = res_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      clr_in   = clr_ff;

      if (cmd.load_req) begin
         op_in    = dllm_pkg::op_type'(req_operation);
         cur_in   = head_ff;
         steps_in = '0;
         res_in   = NONE;
         tgt_in   = item_mapped;
         after_in = NONE;
         case (dllm_pkg::op_type'(req_operation))
            dllm_pkg::OP_INSERT_AFTER: after_in = prev_mapped;
            dllm_pkg::OP_PUSH_BACK:    after_in = tail_ff;
            dllm_pkg::OP_POP_FRONT:    tgt_in   = head_ff;
            default:                   after_in = NONE;
         endcase
      end
      if (cmd.cap_nxt) begin
         nxt_in = (after_ff == NONE) ? head_ff : rd_next_ff;
      end
      if (cmd.cap_links) begin
         p_in = rd_prev_ff;
         n_in = rd_next_ff;
      end
      if (cmd.upd_ins) begin
         res_in = tgt_ff;
         if (after_ff == NONE) begin
            head_in = tgt_ff;
         end
         if (nxt_ff == NONE) begin
            tail_in = tgt_ff;
         end
         if (count_ff < NONE) begin
            count_in = count_ff + LW'(1);
         end
      end
      if (cmd.upd_det) begin
         res_in = tgt_ff;
         if (head_ff == tgt_ff) begin
            head_in = n_ff;
         end
         if (tail_ff == tgt_ff) begin
            tail_in = p_ff;
         end
         if (count_ff != '0) begin
            count_in = count_ff - LW'(1);
         end
      end
      if (cmd.find_step) begin
         cur_in   = rd_next_ff;
         steps_in = steps_ff + LW'(1);
      end
      if (cmd.set_found) begin
         res_in = tgt_ff;
      end
      if (cmd.clr_step) begin
         clr_in = (clr_ff == LAST) ? '0 : clr_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= NONE;
         tail_ff  <= NONE;
         count_ff <= '0;
         clr_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      tgt_ff   <= tgt_in;
      after_ff <= after_in;
      nxt_ff   <= nxt_in;
      p_ff     <= p_in;
      n_ff     <= n_in;
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
      res_ff   <= res_in;
   end

   // Read port shared by both link memories
   always_comb begin
      case (cmd.rd_sel)
         dllm_pkg::RD_AFTER:  rd_addr = after_ff;
         dllm_pkg::RD_CURSOR: rd_addr = cur_ff;
         default:             rd_addr = tgt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_next_ff <= next_mem[rd_addr[IW-1:0]];
         rd_prev_ff <= prev_mem[rd_addr[IW-1:0]];
         rd_addr_ff <= rd_addr;
      end
   end

   // Write port of each link memory
   always_comb begin
      wn_en   = 1'b0;
      wn_addr = tgt_ff[IW-1:0];
      wn_data = NONE;
      wp_en   = 1'b0;
      wp_addr = tgt_ff[IW-1:0];
      wp_data = NONE;
      case (cmd.wr_sel)
         dllm_pkg::WR_CLEAR: begin
            wn_en   = 1'b1;
            wn_addr = clr_ff;
            wp_en   = 1'b1;
            wp_addr = clr_ff;
         end
         dllm_pkg::WR_INS_SELF: begin
            wn_en   = 1'b1;
            wn_data = nxt_ff;
            wp_en   = 1'b1;
            wp_data = after_ff;
         end
         dllm_pkg::WR_INS_NBR: begin
            wn_en   = (after_ff != NONE);
            wn_addr = after_ff[IW-1:0];
            wn_data = tgt_ff;
            wp_en   = (nxt_ff != NONE);
            wp_addr = nxt_ff[IW-1:0];
            wp_data = tgt_ff;
         end
         dllm_pkg::WR_DET_SELF: begin
            wn_en = 1'b1;
            wp_en = 1'b1;
         end
         dllm_pkg::WR_DET_NBR: begin
            wn_en   = (p_ff != NONE);
            wn_addr = p_ff[IW-1:0];
            wn_data = n_ff;
            wp_en   = (n_ff != NONE);
            wp_addr = n_ff[IW-1:0];
            wp_data = p_ff;
         end
         default: begin
            wn_en = 1'b0;
            wp_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wn_en) begin
         next_mem[wn_addr] <= wn_data;
      end
      if (wp_en) begin
         prev_mem[wp_addr] <= wp_data;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_res_ff   <= res_ff;
         out_count_ff <= count_ff;
         out_head_ff  <= head_ff;
         out_tail_ff  <= tail_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = out_res_ff;
   assign rsp_list_count   = out_count_ff;
   assign rsp_head_index   = out_head_ff;
   assign rsp_tail_index   = out_tail_ff;

   always_comb begin
      status.op          = op_ff;
      status.target_ok   = (tgt_ff != NONE);
      status.after_none  = (after_ff == NONE);
      status.rd_member   = (rd_next_ff != NONE) || (rd_prev_ff != NONE) ||
                           (head_ff == rd_addr_ff);
      status.cursor_done = (cur_ff == NONE) || (steps_ff == NONE);
      status.cursor_hit  = (cur_ff == tgt_ff);
      status.clr_last    = (clr_ff == LAST);
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

endmodule

// File: hdl/doubly_linked_list_manager_unit.sv
// Top level of the doubly linked list manager: sequencer plus link datapath.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+------------------------------------------------
//   req_chan  | in  | valid / ready | operation, item_index, prev_index
//   rsp_chan  | out | valid / ready | result_index, list_count, head_index, tail_index
//
// One item is worked at a time; the next is taken once its result sits in the
// output register, even while that result still waits for rsp_chan.ready.
// Steps per item after accept: decode; detach/pop front read and check the target,
// then write its neighbors and then itself; insert and push read the target and,
// behind a node, the anchor, then write the item and then its neighbors; find
// walks from the head (one link-memory read and its registered data per step).
// Refused items and spare codes skip the writes; all end in the finish step, which
// loads the result and returns to idle. After reset a clearing pass sets every link
// to none; no item is taken until it ends. A stalled result holds the sequencer in its last step.
module doubly_linked_list_manager_unit #(
   parameter  int NODES = 64,
   localparam int IW    = $clog2(NODES),
   localparam int LW    = $clog2(NODES + 1)
) (
   input  logic       clock,
   input  logic       reset,
   dllm_req_if.sink   req_chan,
   dllm_rsp_if.source rsp_chan
);

   dllm_pkg::cmd_type    cmd;
   dllm_pkg::status_type status;
   logic                 req_ready;

   // Sequencer: owns the input handshake and drives the datapath steps.
   dllm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // Datapath: link memories, head/tail/count and the result register.
   dllm_datapath #(.NODES(NODES)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_chan.operation),
      .req_item_index   (req_chan.item_index[IW-1:0]),
      .req_prev_index   (req_chan.prev_index[LW-1:0]),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_result_index (rsp_chan.result_index),
      .rsp_list_count   (rsp_chan.list_count),
      .rsp_head_index   (rsp_chan.head_index),
      .rsp_tail_index   (rsp_chan.tail_index)
   );

endmodule

// File: hdl/dllm_checker.sv
// Port-level checks for the list manager and their bind to the top level.
module dllm_checker #(
   parameter  int NODES = 64,
   localparam int LW    = $clog2(NODES + 1)
) (
   input logic        clock,
   input logic        reset,
   dllm_req_if.sink   req_chan,
   dllm_rsp_if.source rsp_chan
);

   localparam logic [LW-1:0] NONE = LW'(NODES);

   logic       req_acc, rsp_acc;
   logic [1:0] pend_ff, pend_in;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign rsp_acc = rsp_chan.valid && rsp_chan.ready;
   assign pend_in = 2'(pend_ff + {1'b0, req_acc} - {1'b0, rsp_acc});

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> pend_ff != 2'd0)
      else $error("result shown with no item outstanding");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid &&
         $stable(rsp_chan.result_index) && $stable(rsp_chan.list_count) &&
         $stable(rsp_chan.head_index) && $stable(rsp_chan.tail_index))
      else $error("stalled result changed");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.list_count == '0 |->
         rsp_chan.head_index == NONE && rsp_chan.tail_index == NONE)
      else $error("empty list reports a head or tail");

   a_nonempty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.list_count != '0 |->
         rsp_chan.head_index != NONE && rsp_chan.tail_index != NONE &&
         (rsp_chan.list_count != LW'(1) || rsp_chan.head_index == rsp_chan.tail_index))
      else $error("head or tail inconsistent with count");

endmodule

bind doubly_linked_list_manager_unit dllm_checker #(.NODES(NODES)) u_dllm_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

// File: bench/tb_doubly_linked_list_manager_unit.sv
// Testbench for the doubly linked list manager: directed and random list traffic against a predictor.
module tb_doubly_linked_list_manager_unit;

   localparam int NODES        = 64;
   localparam int RANDOM_ITEMS = 950;
   localparam int IDLE_PCT     = 30;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 200;

   typedef logic [dllm_pkg::OP_W-1:0] op_code_type;

   // The two spare operation codes; the block answers none and changes nothing.
   localparam op_code_type OP_SPARE_A = 3'd6;
   localparam op_code_type OP_SPARE_B = 3'd7;

   typedef logic [6:0] link_type;
   localparam link_type NIL = link_type'(NODES);

   typedef struct packed {
      op_code_type operation;
      logic [5:0]  item_index;
      logic [6:0]  prev_index;
   } list_op_type;

   typedef struct packed {
      link_type result_index;
      link_type list_count;
      link_type head_index;
      link_type tail_index;
   } list_view_type;

   logic clock = 1'b0;
   logic reset;

   dllm_req_if #(.ITEM_W(6), .LINK_W(7)) req_if ();
   dllm_rsp_if #(.LINK_W(7))             rsp_if ();

   doubly_linked_list_manager_unit #(.NODES(NODES)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Period of 2: high for one unit, low for one unit.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Operations still to be offered, and list views owed by the block, oldest first.
   list_op_type   ops_to_send [$];
   list_view_type views_due [$];

   // Order of the list as the stimulus generator believes it to be; used only to
   // pick members and non-members so that most operations actually do something.
   int plan_order [$];

   // Predicted link tables and list descriptors.
   link_type succ [NODES];
   link_type pred [NODES];
   link_type first_node;
   link_type last_node;
   link_type node_total;

   int mismatches    = 0;
   int ops_taken     = 0;
   int views_checked = 0;
   int hold_left     = 0;
   int holds_done    = 0;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // A node is on the list when it has either neighbor or is the head, which
   // also covers a list of one node.
   function automatic bit on_list(link_type x);
      if (x >= NIL) return 1'b0;
      return succ[x[5:0]] != NIL || pred[x[5:0]] != NIL || first_node == x;
   endfunction

   // Link node in behind after (NIL: at the front). Refuse members, and refuse
   // an anchor that is not on the list.
   function automatic link_type link_in(link_type after, link_type node);
      link_type follower;
      if (node >= NIL || on_list(node)) return NIL;
      if (after != NIL && !on_list(after)) return NIL;
      follower = (after != NIL) ? succ[after[5:0]] : first_node;
      if (after != NIL) begin
         pred[node[5:0]]  = after;
         succ[after[5:0]] = node;
      end else begin
         first_node = node;
      end
      if (follower != NIL) begin
         succ[node[5:0]]     = follower;
         pred[follower[5:0]] = node;
      end else begin
         last_node = node;
      end
      if (node_total < NIL) node_total++;
      return node;
   endfunction

   // Unhook node from both neighbors; a non-member (or NIL, for an empty pop)
   // answers none and leaves the list alone.
   function automatic link_type unlink(link_type node);
      link_type p;
      link_type n;
      if (!on_list(node)) return NIL;
      p = pred[node[5:0]];
      n = succ[node[5:0]];
      if (p != NIL) succ[p[5:0]] = n;
      if (n != NIL) pred[n[5:0]] = p;
      if (first_node == node) first_node = n;
      if (last_node == node) last_node = p;
      succ[node[5:0]] = NIL;
      pred[node[5:0]] = NIL;
      if (node_total > 0) node_total--;
      return node;
   endfunction

   function automatic list_view_type apply_list_op(list_op_type it);
      list_view_type v;
      link_type      node;
      link_type      after;
      link_type      cursor;
      node  = link_type'(it.item_index);
      after = (it.prev_index >= NIL) ? NIL : it.prev_index;
      v.result_index = NIL;
      case (it.operation)
         dllm_pkg::OP_INSERT_AFTER: v.result_index = link_in(after, node);
         dllm_pkg::OP_DETACH:       v.result_index = unlink(node);
         dllm_pkg::OP_FIND: begin
            // Walk from the head, bounded to one pass over the pool.
            cursor = first_node;
            for (int steps = 0; steps < NODES && cursor != NIL; steps++) begin
               if (cursor == node) begin
                  v.result_index = node;
                  break;
               end
               cursor = succ[cursor[5:0]];
            end
         end
         dllm_pkg::OP_PUSH_BACK:    v.result_index = link_in(last_node, node);
         dllm_pkg::OP_PUSH_FRONT:   v.result_index = link_in(NIL, node);
         dllm_pkg::OP_POP_FRONT:    v.result_index = unlink(first_node);
         default:                   v.result_index = NIL;
      endcase
      v.list_count = node_total;
      v.head_index = first_node;
      v.tail_index = last_node;
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus planning
   // ------------------------------------------------------------------

   function automatic int plan_pos(int node);
      foreach (plan_order[i]) if (plan_order[i] == node) return i;
      return -1;
   endfunction

   // Queue one operation and advance the planned list order to match it.
   function automatic void plan_item(op_code_type op, int node, int after);
      list_op_type it;
      int          at;
      it.operation  = op;
      it.item_index = node[5:0];
      it.prev_index = after[6:0];
      ops_to_send.push_back(it);
      at = plan_pos(after);
      case (op)
         dllm_pkg::OP_INSERT_AFTER: begin
            if (plan_pos(node) < 0) begin
               if (after >= NODES) plan_order.push_front(node);
               else if (at >= 0) plan_order.insert(at + 1, node);
            end
         end
         dllm_pkg::OP_DETACH: begin
            if (plan_pos(node) >= 0) plan_order.delete(plan_pos(node));
         end
         dllm_pkg::OP_PUSH_BACK: begin
            if (plan_pos(node) < 0) plan_order.push_back(node);
         end
         dllm_pkg::OP_PUSH_FRONT: begin
            if (plan_pos(node) < 0) plan_order.push_front(node);
         end
         dllm_pkg::OP_POP_FRONT: begin
            if (plan_order.size() != 0) void'(plan_order.pop_front());
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, link_type want, link_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Request driver: offer queued items, predict each one at acceptance
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.operation  <= dllm_pkg::OP_INSERT_AFTER;
         req_if.item_index <= '0;
         req_if.prev_index <= '0;
      end else begin
         // Predict inside the driver so the item leaves the send queue and its
         // view enters the expected queue in one step.
         if (req_if.valid && req_if.ready) begin
            views_due.push_back(apply_list_op(ops_to_send[0]));
            void'(ops_to_send.pop_front());
            ops_taken <= ops_taken + 1;
         end
         // Hold an offered item until it is taken; otherwise offer or idle.
         if (!req_if.valid || req_if.ready) begin
            if (ops_to_send.size() != 0 &&
                ((ops_taken >= 300 && ops_taken < 420) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               req_if.valid      <= 1'b1;
               req_if.operation  <= ops_to_send[0].operation;
               req_if.item_index <= ops_to_send[0].item_index;
               req_if.prev_index <= ops_to_send[0].prev_index;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side: back-pressure and checking
   // ------------------------------------------------------------------

   // Twice in the run, drop ready for a long stretch so the block fills and
   // stalls its input while the driver keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && ops_taken >= 150 + 500 * holds_done) begin
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || hold_left > 0) begin
         rsp_if.ready <= 1'b0;
      end else if (views_checked >= 300 && views_checked < 420) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      list_view_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (views_due.size() == 0) begin
            $error("result with nothing expected: result_index %0d", rsp_if.result_index);
            mismatches++;
         end else begin
            want = views_due.pop_front();
            check_field("result_index", want.result_index, rsp_if.result_index);
            check_field("list_count", want.list_count, rsp_if.list_count);
            check_field("head_index", want.head_index, rsp_if.head_index);
            check_field("tail_index", want.tail_index, rsp_if.tail_index);
         end
         views_checked <= views_checked + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------
   initial begin
      int goal;
      int node;
      int after;
      int pick;
      bit grow;

      reset = 1'b1;

      // Predictor starts from an empty list, as the block does after reset.
      for (int i = 0; i < NODES; i++) begin
         succ[i] = NIL;
         pred[i] = NIL;
      end
      first_node = NIL;
      last_node  = NIL;
      node_total = '0;

      // Directed part: empty-list corners, refused inserts, spare codes, then
      // build a short list and take it apart from the middle, head and tail.
      plan_item(dllm_pkg::OP_POP_FRONT, 0, 0);      // pop with nothing to pop
      plan_item(dllm_pkg::OP_FIND, 0, 0);           // find on an empty list
      plan_item(dllm_pkg::OP_DETACH, 5, 0);         // detach a non-member
      plan_item(dllm_pkg::OP_INSERT_AFTER, 1, 5);   // anchor not on the list
      plan_item(OP_SPARE_A, 63, 127);
      plan_item(OP_SPARE_B, 0, 64);
      plan_item(dllm_pkg::OP_PUSH_FRONT, 0, 0);
      plan_item(dllm_pkg::OP_PUSH_BACK, 63, 0);
      plan_item(dllm_pkg::OP_INSERT_AFTER, 10, 0);  // into the middle
      plan_item(dllm_pkg::OP_INSERT_AFTER, 20, 63); // behind the tail
      plan_item(dllm_pkg::OP_INSERT_AFTER, 0, 127); // member: refused
      plan_item(dllm_pkg::OP_INSERT_AFTER, 30, 64); // none code: at the front
      plan_item(dllm_pkg::OP_INSERT_AFTER, 31, 127);// none code, all ones
      plan_item(dllm_pkg::OP_PUSH_BACK, 63, 0);     // member: refused
      plan_item(dllm_pkg::OP_PUSH_FRONT, 10, 0);    // member: refused
      plan_item(dllm_pkg::OP_FIND, 20, 0);          // longest walk, tail
      plan_item(dllm_pkg::OP_FIND, 31, 0);          // head
      plan_item(dllm_pkg::OP_FIND, 5, 0);           // not on the list
      plan_item(dllm_pkg::OP_DETACH, 10, 0);
      plan_item(dllm_pkg::OP_DETACH, 31, 0);
      plan_item(dllm_pkg::OP_DETACH, 20, 0);
      plan_item(dllm_pkg::OP_POP_FRONT, 0, 0);
      plan_item(dllm_pkg::OP_POP_FRONT, 0, 0);
      plan_item(dllm_pkg::OP_POP_FRONT, 0, 0);      // list empty again
      plan_item(dllm_pkg::OP_PUSH_BACK, 42, 0);     // push back onto an empty list

      // Random part: well-formed traffic steered toward a target length that
      // cycles through a random size, a full pool and an empty list; the rest
      // is raw noise over every field value.
      goal = 0;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 128 == 0) begin
            case ((k / 128) % 3)
               1:       goal = NODES;
               2:       goal = 0;
               default: goal = $urandom_range(NODES);
            endcase
         end
         if ($urandom_range(99) < 15) begin
            plan_item(op_code_type'($urandom_range(7)), $urandom_range(63),
                      $urandom_range(127));
         end else begin
            grow = (plan_order.size() < goal) ? ($urandom_range(99) < 85)
                                              : ($urandom_range(99) < 20);
            if (plan_order.size() == 0) grow = 1'b1;
            if (plan_order.size() == NODES) grow = 1'b0;
            if (grow) begin
               do node = $urandom_range(63); while (plan_pos(node) >= 0);
               pick = $urandom_range(2);
               if (pick == 0) begin
                  if (plan_order.size() != 0 && $urandom_range(99) < 80)
                     after = plan_order[$urandom_range(plan_order.size() - 1)];
                  else
                     after = $urandom_range(127, 64);
                  plan_item(dllm_pkg::OP_INSERT_AFTER, node, after);
               end else if (pick == 1) begin
                  plan_item(dllm_pkg::OP_PUSH_BACK, node, $urandom_range(127));
               end else begin
                  plan_item(dllm_pkg::OP_PUSH_FRONT, node, $urandom_range(127));
               end
            end else begin
               node = plan_order[$urandom_range(plan_order.size() - 1)];
               case ($urandom_range(2))
                  0:       plan_item(dllm_pkg::OP_DETACH, node, $urandom_range(127));
                  1:       plan_item(dllm_pkg::OP_FIND, node, $urandom_range(127));
                  default: plan_item(dllm_pkg::OP_POP_FRONT, $urandom_range(63),
                                     $urandom_range(127));
               endcase
            end
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for every item to go in and every view to come back, then let a
      // longest find walk pass to catch stray results.
      while (ops_to_send.size() != 0 || views_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (views_due.size() != 0) begin
         $error("%0d expected results never arrived", views_due.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Stop a hung run; well beyond the slowest legal run of all-longest walks.
   initial begin
      #1_500_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
